// File: hw/rtl/adsrc_pkg.sv
// adsrc_pkg: types, widths, codes and the fixed-point exp constant table
// for the curved adsr envelope. No dependencies.
`default_nettype none

package adsrc_pkg;

	localparam int TIME_BITS       = 24;
	localparam int LEVEL_FRAC_BITS = 15;
	localparam int CURVE_FRAC_BITS = 12;
	localparam int LOG_TABLE_BITS  = 10;

	localparam int RATIO_BITS   = 24;
	localparam int QB           = 30;
	localparam int QW           = QB + 1;
	localparam int LEVEL_BITS   = LEVEL_FRAC_BITS + 1;
	localparam int CURVE_BITS   = CURVE_FRAC_BITS + 4;
	localparam int CFG_BITS     = TIME_BITS;
	localparam int CFG_IDX_BITS = 3;

	// register stages inside one power unit
	localparam int POW_LAT = RATIO_BITS + 2 * LOG_TABLE_BITS + 5;

	localparam logic [QW-1:0]         Q_ONE     = QW'(1) << QB;
	localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;

	localparam logic [TIME_BITS-1:0]  RST_ATTACK_TIME  = TIME_BITS'(160);
	localparam logic [TIME_BITS-1:0]  RST_DECAY_TIME   = TIME_BITS'(1600);
	localparam logic [LEVEL_BITS-1:0] RST_SUSTAIN      = LEVEL_BITS'(16384);
	localparam logic [TIME_BITS-1:0]  RST_RELEASE_TIME = TIME_BITS'(1600);
	localparam logic [CURVE_BITS-1:0] RST_CURVE        = CURVE_BITS'(4096);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ATTACK_TIME   = 3'd0,
		REG_DECAY_TIME    = 3'd1,
		REG_SUSTAIN_LEVEL = 3'd2,
		REG_RELEASE_TIME  = 3'd3,
		REG_ATTACK_CURVE  = 3'd4,
		REG_DECAY_CURVE   = 3'd5,
		REG_RELEASE_CURVE = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_ATTACK  = 3'd0,
		ST_DECAY   = 3'd1,
		ST_SUSTAIN = 3'd2,
		ST_RELEASE = 3'd3,
		ST_ENDED   = 3'd4
	} stage_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] note_time;
		logic [TIME_BITS-1:0] release_at;
	} in_req_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic [2:0]            stage;
	} out_req_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = x;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// slot k-1 holds 2^(-2^-k) in q1.30
	function automatic logic [LOG_TABLE_BITS*QW-1:0] exp_table();
		logic [LOG_TABLE_BITS*QW-1:0] t;
		logic [63:0] v;
		t = '0;
		v = isqrt64(64'd1 << 59);
		for (int k = 1; k <= LOG_TABLE_BITS; k++) begin
			if (k > 1) begin
				v = isqrt64(v << QB);
			end
			t[(k-1)*QW +: QW] = v[QW-1:0];
		end
		return t;
	endfunction

	localparam logic [LOG_TABLE_BITS*QW-1:0] EXP_TAB = exp_table();

endpackage

`default_nettype wire

// File: hw/rtl/adsrc_pow.sv
// adsrc_pow: pipelined (num/den)^curve in q1.30 via divide, log2 by squaring,
// multiply and exp2 by constant products. Depends on adsrc_pkg.
`default_nettype none

module adsrc_pow (
	input  logic                             clk,
	input  logic                             en,
	input  logic [adsrc_pkg::TIME_BITS-1:0]  num,
	input  logic [adsrc_pkg::TIME_BITS-1:0]  den,
	input  logic [adsrc_pkg::CURVE_BITS-1:0] curve,
	output logic [adsrc_pkg::QW-1:0]         pow
);
	import adsrc_pkg::*;

	localparam int PB  = $clog2(RATIO_BITS);
	localparam int NB  = $clog2(RATIO_BITS + 1);
	localparam int SHW = $clog2(QW);
	localparam int LB  = NB + LOG_TABLE_BITS;
	localparam int MB  = CURVE_BITS + LB;
	localparam int PPB = MB - CURVE_FRAC_BITS;
	localparam int XB  = PPB - LOG_TABLE_BITS;
	localparam int WW  = 2 * QW;
	localparam int LT  = LOG_TABLE_BITS;

	// divider, one quotient bit per stage
	logic [TIME_BITS-1:0]  drem_s [0:RATIO_BITS];
	logic [TIME_BITS-1:0]  dden_s [0:RATIO_BITS];
	logic [RATIO_BITS-1:0] dq_s   [0:RATIO_BITS];
	logic [CURVE_BITS-1:0] dc_s   [0:RATIO_BITS];
	logic [TIME_BITS-1:0]  drem_n [1:RATIO_BITS];
	logic [RATIO_BITS-1:0] dq_n   [1:RATIO_BITS];

	always_comb begin
		logic [TIME_BITS:0] two;
		logic ge;
		for (int k = 1; k <= RATIO_BITS; k++) begin
			two = {drem_s[k-1], 1'b0};
			ge = two >= {1'b0, dden_s[k-1]};
			drem_n[k] = ge ? TIME_BITS'(two - {1'b0, dden_s[k-1]}) : TIME_BITS'(two);
			dq_n[k] = {dq_s[k-1][RATIO_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drem_s[0] <= num;
			dden_s[0] <= den;
			dq_s[0]   <= '0;
			dc_s[0]   <= curve;
			for (int k = 1; k <= RATIO_BITS; k++) begin
				drem_s[k] <= drem_n[k];
				dden_s[k] <= dden_s[k-1];
				dq_s[k]   <= dq_n[k];
				dc_s[k]   <= dc_s[k-1];
			end
		end
	end

	// leading one
	logic [PB-1:0]         msb;
	logic [RATIO_BITS-1:0] n1_f_s;
	logic [PB-1:0]         n1_p_s;
	logic [CURVE_BITS-1:0] n1_c_s;
	logic                  n1_z_s;

	always_comb begin
		msb = '0;
		for (int i = 0; i < RATIO_BITS; i++) begin
			if (dq_s[RATIO_BITS][i]) begin
				msb = PB'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_f_s <= dq_s[RATIO_BITS];
			n1_p_s <= msb;
			n1_c_s <= dc_s[RATIO_BITS];
			n1_z_s <= (dq_s[RATIO_BITS] == '0) && (dc_s[RATIO_BITS] != '0);
		end
	end

	// log2 fraction by repeated squaring, stage 0 is the normalized mantissa
	logic [QW-1:0]         sm_s [0:LT];
	logic [LT-1:0]         sf_s [0:LT];
	logic [PB-1:0]         sp_s [0:LT];
	logic [CURVE_BITS-1:0] sc_s [0:LT];
	logic                  sz_s [0:LT];
	logic [QW-1:0]         sm_n [1:LT];
	logic [LT-1:0]         sf_n [1:LT];

	always_comb begin
		logic [WW-1:0] sq;
		logic [QW:0]   hi;
		for (int k = 1; k <= LT; k++) begin
			sq = WW'(sm_s[k-1]) * WW'(sm_s[k-1]);
			hi = sq[WW-1:QB];
			if (hi[QW]) begin
				sm_n[k] = hi[QW:1];
				sf_n[k] = {sf_s[k-1][LT-2:0], 1'b1};
			end else begin
				sm_n[k] = hi[QW-1:0];
				sf_n[k] = {sf_s[k-1][LT-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s[0] <= {{(QW-RATIO_BITS){1'b0}}, n1_f_s} << (SHW'(QB) - SHW'(n1_p_s));
			sf_s[0] <= '0;
			sp_s[0] <= n1_p_s;
			sc_s[0] <= n1_c_s;
			sz_s[0] <= n1_z_s;
			for (int k = 1; k <= LT; k++) begin
				sm_s[k] <= sm_n[k];
				sf_s[k] <= sf_n[k];
				sp_s[k] <= sp_s[k-1];
				sc_s[k] <= sc_s[k-1];
				sz_s[k] <= sz_s[k-1];
			end
		end
	end

	// exponent product and exp2 by constant factors
	logic [LB-1:0]  lval;
	logic [MB-1:0]  prod;
	logic [QW-1:0]  ey_s  [0:LT];
	logic [LT-1:0]  er_s  [0:LT];
	logic [XB-1:0]  esh_s [0:LT];
	logic           ez_s  [0:LT];
	logic [QW-1:0]  ey_n  [1:LT];
	logic [QW-1:0]  pow_q;

	assign lval = {NB'(NB'(RATIO_BITS) - NB'(sp_s[LT])), {LT{1'b0}}} - LB'(sf_s[LT]);
	assign prod = MB'(sc_s[LT]) * MB'(lval);

	always_comb begin
		logic [WW-1:0] yp;
		for (int k = 1; k <= LT; k++) begin
			yp = WW'(ey_s[k-1]) * WW'(EXP_TAB[(k-1)*QW +: QW]);
			ey_n[k] = er_s[k-1][LT-k] ? yp[QB +: QW] : ey_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ey_s[0]  <= Q_ONE;
			er_s[0]  <= prod[CURVE_FRAC_BITS +: LT];
			esh_s[0] <= prod[MB-1 -: XB];
			ez_s[0]  <= sz_s[LT];
			for (int k = 1; k <= LT; k++) begin
				ey_s[k]  <= ey_n[k];
				er_s[k]  <= er_s[k-1];
				esh_s[k] <= esh_s[k-1];
				ez_s[k]  <= ez_s[k-1];
			end
			if (ez_s[LT] || (32'(esh_s[LT]) >= 32'(QW))) begin
				pow_q <= '0;
			end else begin
				pow_q <= ey_s[LT] >> esh_s[LT];
			end
		end
	end

	assign pow = pow_q;

endmodule

`default_nettype wire

// File: hw/rtl/adsr_curved_envelope.sv
// adsr_curved_envelope: stateless curved adsr envelope, level and stage per request.
// Depends on adsrc_pkg and adsrc_pow.
//
//   port group       | handshake             | content
//   -----------------+-----------------------+-------------------------------
//   in_*  (request)  | in_valid / in_stall   | note_time, release_at
//   out_* (result)   | out_valid / out_stall | level q1.15, stage
//   wr_*  (config)   | wr_en                 | wr_index, wr_data
//
// one request per cycle while in_stall is low; path: stages 1, 2, power units, f1, output register
// latency is set by the 24-step divider and the two 10-step multiply chains
// reset loads register defaults and empties the pipeline; no clearing pass
// a stalled output freezes the pipeline only when its last stage is full
`default_nettype none

module adsr_curved_envelope (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [adsrc_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [adsrc_pkg::CFG_BITS-1:0]      wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  adsrc_pkg::in_req_t                  in_req,
	output logic                                out_valid,
	input  logic                                out_stall,
	output adsrc_pkg::out_req_t                 out_req
);
	import adsrc_pkg::*;

	localparam int MW = LEVEL_BITS + QW;

	typedef struct packed {
		logic   v;
		stage_t hst;
		stage_t fst;
	} sb_t;

	logic [TIME_BITS-1:0]  attack_time_q;
	logic [TIME_BITS-1:0]  decay_time_q;
	logic [LEVEL_BITS-1:0] sustain_q;
	logic [TIME_BITS-1:0]  release_time_q;
	logic [CURVE_BITS-1:0] attack_curve_q;
	logic [CURVE_BITS-1:0] decay_curve_q;
	logic [CURVE_BITS-1:0] release_curve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_time_q   <= RST_ATTACK_TIME;
			decay_time_q    <= RST_DECAY_TIME;
			sustain_q       <= RST_SUSTAIN;
			release_time_q  <= RST_RELEASE_TIME;
			attack_curve_q  <= RST_CURVE;
			decay_curve_q   <= RST_CURVE;
			release_curve_q <= RST_CURVE;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_ATTACK_TIME:   attack_time_q   <= wr_data[TIME_BITS-1:0];
				REG_DECAY_TIME:    decay_time_q    <= wr_data[TIME_BITS-1:0];
				REG_SUSTAIN_LEVEL: sustain_q       <= wr_data[LEVEL_BITS-1:0];
				REG_RELEASE_TIME:  release_time_q  <= wr_data[TIME_BITS-1:0];
				REG_ATTACK_CURVE:  attack_curve_q  <= wr_data[CURVE_BITS-1:0];
				REG_DECAY_CURVE:   decay_curve_q   <= wr_data[CURVE_BITS-1:0];
				REG_RELEASE_CURVE: release_curve_q <= wr_data[CURVE_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid_q;
	logic f1_v_s;

	assign en       = !(out_valid_q && out_stall && f1_v_s);
	assign in_stall = !en;

	// stage 1: input register
	logic                 s1_v_s;
	logic [TIME_BITS-1:0] s1_t_s;
	logic [TIME_BITS-1:0] s1_rel_s;

	// stage 2: held or release split
	logic                 s2_v_s;
	logic                 s2_held_s;
	logic [TIME_BITS-1:0] s2_te_s;
	logic [TIME_BITS-1:0] s2_r_s;
	logic                 held;

	assign held = (s1_rel_s == {TIME_BITS{1'b1}}) || (s1_t_s < s1_rel_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s <= 1'b0;
			s2_v_s <= 1'b0;
		end else if (en) begin
			s1_v_s <= in_valid;
			s2_v_s <= s1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_t_s    <= in_req.note_time;
			s1_rel_s  <= in_req.release_at;
			s2_held_s <= held;
			s2_te_s   <= held ? s1_t_s : s1_rel_s;
			s2_r_s    <= s1_t_s - s1_rel_s;
		end
	end

	// stage select feeding the held power unit; the release power unit takes the stage 2 release time
	logic                  a_hit;
	logic                  d_hit;
	logic                  r_hit;
	logic [TIME_BITS-1:0]  t2;
	logic [TIME_BITS-1:0]  ha_num;
	logic [TIME_BITS-1:0]  ha_den;
	logic [CURVE_BITS-1:0] ha_curve;
	sb_t                   sb_in;

	assign a_hit    = s2_te_s < attack_time_q;
	assign t2       = s2_te_s - attack_time_q;
	assign d_hit    = t2 < decay_time_q;
	assign r_hit    = s2_r_s < release_time_q;
	assign ha_num   = a_hit ? s2_te_s : t2;
	assign ha_den   = a_hit ? attack_time_q : decay_time_q;
	assign ha_curve = a_hit ? attack_curve_q : decay_curve_q;

	always_comb begin
		sb_in.v   = s2_v_s;
		sb_in.hst = a_hit ? ST_ATTACK : (d_hit ? ST_DECAY : ST_SUSTAIN);
		if (s2_held_s) begin
			sb_in.fst = sb_in.hst;
		end else begin
			sb_in.fst = r_hit ? ST_RELEASE : ST_ENDED;
		end
	end

	logic [QW-1:0] pow_held;
	logic [QW-1:0] pow_rel;

	adsrc_pow u_pow_held (
		.clk   (clk),
		.en    (en),
		.num   (ha_num),
		.den   (ha_den),
		.curve (ha_curve),
		.pow   (pow_held)
	);

	adsrc_pow u_pow_rel (
		.clk   (clk),
		.en    (en),
		.num   (s2_r_s),
		.den   (release_time_q),
		.curve (release_curve_q),
		.pow   (pow_rel)
	);

	sb_t sb_s [0:POW_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < POW_LAT; k++) begin
				sb_s[k] <= '0;
			end
		end else if (en) begin
			sb_s[0] <= sb_in;
			for (int k = 1; k < POW_LAT; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
		end
	end

	// held level
	logic [LEVEL_BITS-1:0] sus;
	logic [MW-1:0]         dec_m;
	logic [LEVEL_BITS-1:0] base;
	sb_t                   sb_end;

	assign sb_end = sb_s[POW_LAT-1];
	assign sus    = (sustain_q > LEVEL_ONE) ? LEVEL_ONE : sustain_q;
	assign dec_m  = MW'(LEVEL_ONE - sus) * MW'(pow_held);

	always_comb begin
		case (sb_end.hst)
			ST_ATTACK: base = LEVEL_BITS'(pow_held >> (QB - LEVEL_FRAC_BITS));
			ST_DECAY:  base = LEVEL_ONE - LEVEL_BITS'(dec_m >> QB);
			default:   base = sus;
		endcase
	end

	logic [LEVEL_BITS-1:0] f1_base_s;
	logic [QW-1:0]         f1_powb_s;
	stage_t                f1_st_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_v_s <= 1'b0;
		end else if (en) begin
			f1_v_s <= sb_end.v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_base_s <= base;
			f1_powb_s <= pow_rel;
			f1_st_s   <= sb_end.fst;
		end
	end

	// release scaling and output register
	logic [MW-1:0]         rel_m;
	logic [LEVEL_BITS-1:0] lvl;
	out_req_t              out_req_q;

	assign rel_m = MW'(f1_base_s) * MW'(Q_ONE - f1_powb_s);

	always_comb begin
		case (f1_st_s)
			ST_RELEASE: lvl = LEVEL_BITS'(rel_m >> QB);
			ST_ENDED:   lvl = '0;
			default:    lvl = f1_base_s;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= f1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_req_q.level <= lvl;
			out_req_q.stage <= f1_st_s;
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output not blocked");

	a_ended_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_req.stage == ST_ENDED)) |-> (out_req.level == '0))
		else $error("ended stage with nonzero level");

	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_req.level <= LEVEL_ONE))
		else $error("level above full scale");

	a_sustain_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_req.stage == ST_SUSTAIN)) |-> (out_req.level == sus))
		else $error("sustain stage level differs from sustain register");

endmodule

`default_nettype wire

// File: dv/tb_adsr_curved_envelope.sv
// tb_adsr_curved_envelope: self-checking testbench for the curved adsr envelope.
// Drives requests (directed rows then random), predicts level and stage, checks results.
// Depends on adsrc_pkg and adsr_curved_envelope.
`default_nettype none

module tb_adsr_curved_envelope;
	import adsrc_pkg::*;

	localparam int LAT       = 53;
	localparam int WD_LIMIT  = 2000;
	localparam int N_RANDOM  = 500;
	localparam logic [TIME_BITS-1:0] HELD = '1;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_BITS-1:0] wr_index;
	logic [CFG_BITS-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	in_req_t in_req;
	logic out_valid;
	logic out_stall;
	out_req_t out_req;

	adsr_curved_envelope uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
		.out_valid(out_valid), .out_stall(out_stall), .out_req(out_req)
	);

	// register shadow
	logic [TIME_BITS-1:0]  atk_t, dec_t, rel_t;
	logic [LEVEL_BITS-1:0] sus_lvl;
	logic [CURVE_BITS-1:0] atk_c, dec_c, rel_c;
	logic [63:0] pow_consts [1:LOG_TABLE_BITS];

	out_req_t level_queue[$];
	int errors;
	int idle_cycles;
	bit done_stim;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] sq_root(input logic [63:0] x);
		logic [63:0] v, r, b;
		v = x;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// (t/span)^c in q1.30
	function automatic logic [63:0] ratio_power(input logic [63:0] t, input logic [63:0] span,
			input logic [63:0] c);
		logic [63:0] f, m, frac, lg, pr, n, r, y;
		int p;
		y = 64'd1 << QB;
		frac = 0;
		if (c == 0) return 64'd1 << QB;
		if (span == 0) return 0;
		f = (t << RATIO_BITS) / span;
		if (f == 0) return 0;
		p = 0;
		for (int i = 0; i < RATIO_BITS; i++) if (f[i]) p = i;
		m = f << (QB - p);
		for (int i = 0; i < LOG_TABLE_BITS; i++) begin
			m = (m * m) >> QB;
			frac = frac << 1;
			if (m >= (64'd2 << QB)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		lg = (64'(RATIO_BITS - p) << LOG_TABLE_BITS) - frac;
		pr = (c * lg) >> CURVE_FRAC_BITS;
		n = pr >> LOG_TABLE_BITS;
		r = pr & ((64'd1 << LOG_TABLE_BITS) - 1);
		for (int k = 1; k <= LOG_TABLE_BITS; k++)
			if (r[LOG_TABLE_BITS-k]) y = (y * pow_consts[k]) >> QB;
		if (n >= 31) return 0;
		return y >> n;
	endfunction

	function automatic logic [63:0] held_envelope(input logic [63:0] t, output stage_t st);
		logic [63:0] s, t2;
		s = (sus_lvl > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(sus_lvl);
		if (t < atk_t) begin
			st = ST_ATTACK;
			return ratio_power(t, atk_t, atk_c) >> (QB - LEVEL_FRAC_BITS);
		end
		t2 = t - atk_t;
		if (t2 < dec_t) begin
			st = ST_DECAY;
			return 64'(LEVEL_ONE) - (((64'(LEVEL_ONE) - s) * ratio_power(t2, dec_t, dec_c)) >> QB);
		end
		st = ST_SUSTAIN;
		return s;
	endfunction

	function automatic out_req_t envelope_of(input in_req_t rq);
		out_req_t o;
		stage_t st;
		logic [63:0] lvl, base, r;
		if (rq.release_at == HELD || rq.note_time < rq.release_at) begin
			lvl = held_envelope(rq.note_time, st);
		end else begin
			r = rq.note_time - rq.release_at;
			if (r < rel_t) begin
				base = held_envelope(rq.release_at, st);
				st = ST_RELEASE;
				lvl = (base * ((64'd1 << QB) - ratio_power(r, rel_t, rel_c))) >> QB;
			end else begin
				st = ST_ENDED;
				lvl = 0;
			end
		end
		o.level = lvl[LEVEL_BITS-1:0];
		o.stage = st;
		return o;
	endfunction

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_ATTACK_TIME:   atk_t = val[TIME_BITS-1:0];
			REG_DECAY_TIME:    dec_t = val[TIME_BITS-1:0];
			REG_SUSTAIN_LEVEL: sus_lvl = val[LEVEL_BITS-1:0];
			REG_RELEASE_TIME:  rel_t = val[TIME_BITS-1:0];
			REG_ATTACK_CURVE:  atk_c = val[CURVE_BITS-1:0];
			REG_DECAY_CURVE:   dec_c = val[CURVE_BITS-1:0];
			default:           rel_c = val[CURVE_BITS-1:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (level_queue.size() != 0) @(posedge clk);
	endtask

	// one request; if has_exp the row's typed result must also match the predictor
	task automatic send_request(input in_req_t rq, input bit has_exp, input out_req_t exp_o);
		out_req_t p;
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = envelope_of(rq);
		if (has_exp && p !== exp_o) begin
			$error("directed row: predicted %p, typed %p", p, exp_o);
			errors++;
		end
		in_valid <= 1'b1;
		in_req <= rq;
		do @(posedge clk); while (in_stall);
		level_queue.push_back(p);
	endtask

	typedef struct {
		logic [TIME_BITS-1:0] nt;
		logic [TIME_BITS-1:0] ra;
		bit has_exp;
		logic [LEVEL_BITS-1:0] lvl;
		stage_t st;
	} row_t;

	row_t rows[$];

	task automatic random_phase(input int count);
		in_req_t rq;
		int span;
		for (int i = 0; i < count; i++) begin
			span = atk_t + dec_t + rel_t + 4;
			case ($urandom_range(0, 5))
				0: rq = '{note_time: $urandom, release_at: $urandom};
				1: rq = '{note_time: $urandom_range(0, span), release_at: HELD};
				2: rq = '{note_time: HELD, release_at: $urandom};
				default: begin
					rq.release_at = $urandom_range(0, atk_t + dec_t + 4);
					rq.note_time = rq.release_at + $urandom_range(0, rel_t + 4);
				end
			endcase
			send_request(rq, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_req_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (level_queue.size() == 0) begin
				$error("unexpected result %p", out_req);
				errors++;
			end else begin
				e = level_queue.pop_front();
				if (out_req.level !== e.level) begin
					$error("level: expected %0d, actual %0d", e.level, out_req.level);
					errors++;
				end
				if (out_req.stage !== e.stage) begin
					$error("stage: expected %0d, actual %0d", e.stage, out_req.stage);
					errors++;
				end
			end
		end
	end

	// receiver stall
	initial begin
		int w;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
				if (w != 0) out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || done_stim)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("adsr_curved_envelope regression: fail");
			$finish;
		end
	end

	initial begin
		int c;
		errors = 0;
		idle_cycles = 0;
		done_stim = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		in_req = '0;
		pow_consts[1] = sq_root(64'd1 << 59);
		for (int k = 2; k <= LOG_TABLE_BITS; k++) pow_consts[k] = sq_root(pow_consts[k-1] << QB);
		atk_t = 160; dec_t = 1600; sus_lvl = 16384; rel_t = 1600;
		atk_c = 4096; dec_c = 4096; rel_c = 4096;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows at reset settings
		rows = '{
			'{0, HELD, 1, 0, ST_ATTACK},
			'{HELD, HELD, 1, 16384, ST_SUSTAIN},
			'{80, HELD, 1, 0, ST_ATTACK},
			'{159, HELD, 0, 0, ST_ATTACK},
			'{160, HELD, 1, 32768, ST_DECAY},
			'{960, HELD, 0, 0, ST_DECAY},
			'{1760, HELD, 1, 16384, ST_SUSTAIN},
			'{2000, 2000, 1, 16384, ST_RELEASE},
			'{2800, 2000, 0, 0, ST_RELEASE},
			'{3600, 2000, 1, 0, ST_ENDED},
			'{HELD, 0, 1, 0, ST_ENDED},
			'{100, 50, 0, 0, ST_RELEASE},
			'{500, 600, 0, 0, ST_DECAY},
			'{1000, 160, 0, 0, ST_RELEASE},
			'{HELD - 1, HELD - 2, 0, 0, ST_RELEASE}
		};
		rows[2].lvl = 16384;
		foreach (rows[i])
			send_request('{note_time: rows[i].nt, release_at: rows[i].ra}, rows[i].has_exp,
				'{level: rows[i].lvl, stage: rows[i].st});
		drain();
		repeat (LAT) @(posedge clk);

		// extremes, zero curves, zero durations, sustain above full scale
		write_reg(REG_ATTACK_TIME, 0);
		write_reg(REG_DECAY_TIME, 0);
		write_reg(REG_SUSTAIN_LEVEL, 16'hFFFF);
		write_reg(REG_RELEASE_TIME, 0);
		send_request('{note_time: 5, release_at: HELD}, 1'b1, '{level: 32768, stage: ST_SUSTAIN});
		send_request('{note_time: 5, release_at: 5}, 1'b1, '{level: 0, stage: ST_ENDED});
		drain();
		write_reg(REG_ATTACK_TIME, 100);
		write_reg(REG_DECAY_TIME, 100);
		write_reg(REG_RELEASE_TIME, 100);
		write_reg(REG_ATTACK_CURVE, 0);
		write_reg(REG_DECAY_CURVE, 0);
		write_reg(REG_RELEASE_CURVE, 0);
		write_reg(REG_SUSTAIN_LEVEL, 0);
		send_request('{note_time: 0, release_at: HELD}, 1'b1, '{level: 32768, stage: ST_ATTACK});
		send_request('{note_time: 150, release_at: HELD}, 1'b1, '{level: 0, stage: ST_DECAY});
		send_request('{note_time: 20, release_at: 10}, 1'b1, '{level: 0, stage: ST_RELEASE});
		random_phase(40);
		drain();
		repeat (LAT) @(posedge clk);

		// several random settings, max values included
		for (int ph = 0; ph < 6; ph++) begin
			c = (ph == 0) ? 65535 : $urandom_range(0, 16383);
			write_reg(REG_ATTACK_TIME, (ph == 1) ? HELD : $urandom_range(0, 3000));
			write_reg(REG_DECAY_TIME, (ph == 1) ? HELD : $urandom_range(0, 3000));
			write_reg(REG_RELEASE_TIME, (ph == 1) ? HELD : $urandom_range(0, 3000));
			write_reg(REG_SUSTAIN_LEVEL, $urandom_range(0, 32768));
			write_reg(REG_ATTACK_CURVE, c);
			write_reg(REG_DECAY_CURVE, (ph == 0) ? 65535 : $urandom_range(0, 16383));
			write_reg(REG_RELEASE_CURVE, (ph == 0) ? 65535 : $urandom_range(0, 16383));
			random_phase(N_RANDOM / 6);
			drain();
			repeat (LAT) @(posedge clk);
		end

		done_stim = 1'b1;
		repeat (LAT + 10) @(posedge clk);
		if (errors == 0 && level_queue.size() == 0)
			$display("adsr_curved_envelope regression: pass");
		else
			$display("adsr_curved_envelope regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/adsrc_pkg.sv
hw/rtl/adsrc_pow.sv
hw/rtl/adsr_curved_envelope.sv
dv/tb_adsr_curved_envelope.sv
